// ===== src/cckb_pkg.sv =====
`timescale 1ns / 1ps
package cckb_pkg;

  localparam int SPAN_W    = 16;
  localparam int STEP_W    = 16;
  localparam int CNT_W     = 4;
  localparam int CH_W      = 8;
  localparam int WORD_W    = 32;
  localparam int PAIR_W    = 64;
  localparam int NUM_PAIRS = 4;
  localparam int PT_IDX_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int DIVD_W    = 24;
  localparam int QUO_W     = 8;
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = 3;
  localparam int NUM_CH    = 3;

  localparam logic [CH_W-1:0] CH_FULL = 8'd255;
  localparam logic [CH_W-1:0] GREY    = 8'd127;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_SPAN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_3      = 3'd5;

  localparam logic [SPAN_W-1:0] RST_TIME_SPAN   = 16'd1000;
  localparam logic [CNT_W-1:0]  RST_POINT_COUNT = 4'd3;
  localparam logic [PAIR_W-1:0] RST_PAIR_0      = 64'h0000_FF55_FF00_0000;
  localparam logic [PAIR_W-1:0] RST_PAIR_1      = 64'h0000_0000_00FF_00AA;
  localparam logic [PAIR_W-1:0] RST_PAIR_2      = 64'h0;
  localparam logic [PAIR_W-1:0] RST_PAIR_3      = 64'h0;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PHASE_GO,
    S_PHASE_WAIT,
    S_SELECT,
    S_SEARCH,
    S_RATIO_GO,
    S_RATIO_WAIT,
    S_MIX,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [SPAN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  typedef logic [PAIR_W-1:0] pairs_t [NUM_PAIRS];

  function automatic logic [WORD_W-1:0] point_word(input pairs_t pairs,
                                                   input logic [PT_IDX_W-1:0] idx);
    logic [PAIR_W-1:0] pair;
    pair = pairs[idx[PT_IDX_W-1:1]];
    return idx[0] ? pair[PAIR_W-1:WORD_W] : pair[WORD_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] chan_byte(input logic [WORD_W-1:0] w,
                                                input chan_t ch);
    logic [CH_W-1:0] b;
    unique case (ch)
      CH_RED:   b = w[15:8];
      CH_GREEN: b = w[23:16];
      CH_BLUE:  b = w[31:24];
      default:  b = w[15:8];
    endcase
    return b;
  endfunction

endpackage

// ===== src/cckb_div.sv =====
`timescale 1ns / 1ps
module cckb_div (
  input  logic               clk,
  input  logic               rst_n,
  input  cckb_pkg::div_req_t req,
  output cckb_pkg::div_rsp_t rsp
);
  import cckb_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SPAN_W-1:0]    rem_r;
  logic [QUO_W-1:0]     quo_r;
  logic [SPAN_W-1:0]    divisor_r;
  logic [SPAN_W:0]      trial;
  logic [SPAN_W:0]      diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle; the upper dividend part
  // is below the divisor so the quotient fits QUO_W bits
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign ge    = trial >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r     <= req.dividend[DIVD_W-1:QUO_W];
      quo_r     <= req.dividend[QUO_W-1:0];
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== src/cyclic_color_keyframe_blender.sv =====
`timescale 1ns / 1ps
// channel | handshake              | payload
// in      | in_valid / in_ready    | in_time_step[15:0]
// out     | out_valid / out_ready  | out_red, out_green, out_blue, out_phase [7:0]
// cfg     | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[63:0]
//
// A transaction runs a phase divide; with two or more points it then adds one
// search step per inner point (up to MAX_POINTS-2) when the phase lies between
// the first and last point, and a second divider pass when the blend ratio needs it.
// in_ready is high only in idle; a finished result waits in the output register
// while the next transaction is accepted. cfg_ready is always high.
// Reset (rst_n, synchronous) loads the default span, points and zero time.
module cyclic_color_keyframe_blender #(
  parameter int MAX_POINTS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cckb_pkg::STEP_W-1:0]       in_time_step,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cckb_pkg::CH_W-1:0]         out_red,
  output logic [cckb_pkg::CH_W-1:0]         out_green,
  output logic [cckb_pkg::CH_W-1:0]         out_blue,
  output logic [cckb_pkg::QUO_W-1:0]        out_phase,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cckb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cckb_pkg::PAIR_W-1:0]       cfg_data
);
  import cckb_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  state_t            state_r, state_nxt;
  logic [SPAN_W-1:0] time_span_r;
  logic [CNT_W-1:0]  point_count_r;
  pairs_t            pairs_r;
  logic [SPAN_W-1:0] elapsed_r;
  logic [QUO_W-1:0]  phase_r, phase_nxt;
  logic [WORD_W-1:0] lw_r, lw_nxt, rw_r, rw_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CH_W-1:0]   ratio_r, ratio_nxt;
  chan_t             ch_r, ch_nxt;
  logic [CH_W-1:0]   color_r [NUM_CH];
  logic [CH_W-1:0]   color_nxt [NUM_CH];
  logic              out_valid_r;
  logic              out_load;
  logic [CH_W-1:0]   out_red_r, out_green_r, out_blue_r, out_phase_r;

  logic [SPAN_W-1:0] span_eff;
  logic [CNT_W-1:0]  n_eff;
  logic [SPAN_W:0]   t_sum, t_sub;
  logic [SPAN_W-1:0] t_new;
  logic              in_acc;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [WORD_W-1:0] w_first, w_last, w_cur;
  logic [CH_W-1:0]   prog, span_lr;
  logic [CH_W-1:0]   mix_a, mix_b;
  logic [SPAN_W:0]   mix_x;
  logic [SPAN_W:0]   mix_q;

  assign span_eff = (time_span_r == '0) ? SPAN_W'(1) : time_span_r;
  assign n_eff    = (point_count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                          : point_count_r;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // time advance with single wrap and saturation
  always_comb begin
    t_sum = {1'b0, elapsed_r} + {1'b0, in_time_step};
    t_sub = t_sum - {1'b0, span_eff};
    if (t_sum < {1'b0, span_eff}) begin
      t_new = t_sum[SPAN_W-1:0];
    end else if (t_sub < {1'b0, span_eff}) begin
      t_new = t_sub[SPAN_W-1:0];
    end else begin
      t_new = span_eff - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_span_r   <= RST_TIME_SPAN;
      point_count_r <= RST_POINT_COUNT;
      pairs_r[0]    <= RST_PAIR_0;
      pairs_r[1]    <= RST_PAIR_1;
      pairs_r[2]    <= RST_PAIR_2;
      pairs_r[3]    <= RST_PAIR_3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIME_SPAN:   time_span_r   <= cfg_data[SPAN_W-1:0];
        REG_POINT_COUNT: point_count_r <= cfg_data[CNT_W-1:0];
        REG_PAIR_0:      pairs_r[0]    <= cfg_data;
        REG_PAIR_1:      pairs_r[1]    <= cfg_data;
        REG_PAIR_2:      pairs_r[2]    <= cfg_data;
        REG_PAIR_3:      pairs_r[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (in_acc) begin
      elapsed_r <= t_new;
    end
  end

  cckb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign w_first = point_word(pairs_r, '0);
  assign w_last  = point_word(pairs_r, PT_IDX_W'(n_eff - 1'b1));
  assign w_cur   = point_word(pairs_r, PT_IDX_W'(idx_r));
  assign prog    = phase_r - lw_r[7:0];
  assign span_lr = rw_r[7:0] - lw_r[7:0];

  // blend of one channel, then exact divide by 255 for values below 65535
  assign mix_a = chan_byte(lw_r, ch_r);
  assign mix_b = chan_byte(rw_r, ch_r);
  assign mix_x = (SPAN_W+1)'({8'd0, mix_a} * {8'd0, CH_FULL - ratio_r}) +
                 (SPAN_W+1)'({8'd0, mix_b} * {8'd0, ratio_r});
  assign mix_q = (mix_x + (mix_x >> 8) + 1'b1) >> 8;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    lw_nxt       = lw_r;
    rw_nxt       = rw_r;
    idx_nxt      = idx_r;
    ratio_nxt    = ratio_r;
    ch_nxt       = ch_r;
    color_nxt    = color_r;
    out_load     = 1'b0;
    div_req      = '0;
    div_req.divisor  = span_eff;
    div_req.dividend = {elapsed_r, 8'd0} - DIVD_W'(elapsed_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_PHASE_GO;
        end
      end
      S_PHASE_GO: begin
        div_req.start = 1'b1;
        state_nxt     = S_PHASE_WAIT;
      end
      S_PHASE_WAIT: begin
        if (div_rsp.done) begin
          phase_nxt = div_rsp.quotient;
          state_nxt = S_SELECT;
        end
      end
      S_SELECT: begin
        priority if (n_eff == '0) begin
          color_nxt[0] = GREY;
          color_nxt[1] = GREY;
          color_nxt[2] = GREY;
          state_nxt    = S_FINISH;
        end else if (n_eff == CNT_W'(1)) begin
          color_nxt[0] = chan_byte(w_first, CH_RED);
          color_nxt[1] = chan_byte(w_first, CH_GREEN);
          color_nxt[2] = chan_byte(w_first, CH_BLUE);
          state_nxt    = S_FINISH;
        end else if (phase_r <= w_first[7:0] || phase_r >= w_last[7:0]) begin
          lw_nxt    = w_last;
          rw_nxt    = w_first;
          state_nxt = S_RATIO_GO;
        end else begin
          lw_nxt    = w_first;
          rw_nxt    = w_last;
          idx_nxt   = IDX_W'(1);
          state_nxt = (n_eff > CNT_W'(2)) ? S_SEARCH : S_RATIO_GO;
        end
      end
      S_SEARCH: begin
        if (w_cur[7:0] <= phase_r && w_cur[7:0] > lw_r[7:0]) begin
          lw_nxt = w_cur;
        end
        if (w_cur[7:0] >= phase_r && w_cur[7:0] < rw_r[7:0]) begin
          rw_nxt = w_cur;
        end
        idx_nxt = idx_r + 1'b1;
        if (CNT_W'(idx_r) + CNT_W'(2) == n_eff) begin
          state_nxt = S_RATIO_GO;
        end
      end
      S_RATIO_GO: begin
        ch_nxt = CH_RED;
        priority if (span_lr == '0) begin
          ratio_nxt = '0;
          state_nxt = S_MIX;
        end else if (prog >= span_lr) begin
          ratio_nxt = CH_FULL;
          state_nxt = S_MIX;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVD_W'({prog, 8'd0} - {8'd0, prog});
          div_req.divisor  = SPAN_W'(span_lr);
          state_nxt        = S_RATIO_WAIT;
        end
      end
      S_RATIO_WAIT: begin
        if (div_rsp.done) begin
          ratio_nxt = div_rsp.quotient;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        color_nxt[ch_r] = mix_q[CH_W-1:0];
        unique case (ch_r)
          CH_RED:   ch_nxt = CH_GREEN;
          CH_GREEN: ch_nxt = CH_BLUE;
          default:  state_nxt = S_FINISH;
        endcase
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    lw_r    <= lw_nxt;
    rw_r    <= rw_nxt;
    idx_r   <= idx_nxt;
    ratio_r <= ratio_nxt;
    ch_r    <= ch_nxt;
    color_r <= color_nxt;
    if (out_load) begin
      out_red_r   <= color_r[0];
      out_green_r <= color_r[1];
      out_blue_r  <= color_r[2];
      out_phase_r <= phase_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_phase = out_phase_r;

`ifndef ASSERT_OFF
  a_elapsed_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (elapsed_r < $past(span_eff)))
    else $error("elapsed time not below span");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_PHASE_WAIT || state_r == S_RATIO_WAIT))
    else $error("divider result with nobody waiting");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && !out_ready) |=>
      (state_r == S_FINISH && out_valid_r))
    else $error("pending result overwritten");
`endif

endmodule

// ===== sim/tb_cyclic_color_keyframe_blender.sv =====
`timescale 1ns / 1ps
module tb_cyclic_color_keyframe_blender;
  import cckb_pkg::*;

  localparam int KEYS         = 8;
  localparam int IDLE_PCT     = 28;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_SETUPS  = 13;
  localparam int SETUP_STEPS  = 145;
  localparam int PRINT_CAP    = 100;

  // unmapped register slots, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [QUO_W-1:0] phase;
  } color_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [STEP_W-1:0]    in_time_step = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [CH_W-1:0]      out_red;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_blue;
  logic [QUO_W-1:0]     out_phase;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [PAIR_W-1:0]    cfg_data     = '0;

  // expected-color state
  logic [SPAN_W-1:0] key_span;
  logic [CNT_W-1:0]  key_count;
  logic [PAIR_W-1:0] key_pairs [NUM_PAIRS];
  logic [SPAN_W-1:0] timeline;

  logic [PAIR_W-1:0] plan_pairs [NUM_PAIRS];
  logic [STEP_W-1:0] step_pending [$];
  color_t            color_expected [$];

  bit step_taken  = 1'b0;
  bit steady      = 1'b0;
  bit pressure_go = 1'b0;
  bit rx_hold     = 1'b0;
  int errors      = 0;
  int n_queued    = 0;
  int n_items     = 0;
  int n_results   = 0;
  int n_writes    = 0;
  int n_setups    = 0;
  int stall_cnt   = 0;

  cyclic_color_keyframe_blender #(
    .MAX_POINTS(KEYS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_time_step(in_time_step),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_phase   (out_phase),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void reset_keys();
    key_span     = RST_TIME_SPAN;
    key_count    = RST_POINT_COUNT;
    key_pairs[0] = RST_PAIR_0;
    key_pairs[1] = RST_PAIR_1;
    key_pairs[2] = RST_PAIR_2;
    key_pairs[3] = RST_PAIR_3;
    timeline     = '0;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [PAIR_W-1:0] data);
    case (idx)
      REG_TIME_SPAN:   key_span = data[SPAN_W-1:0];
      REG_POINT_COUNT: key_count = data[CNT_W-1:0];
      REG_PAIR_0, REG_PAIR_1, REG_PAIR_2, REG_PAIR_3:
        key_pairs[idx[1:0] - REG_PAIR_0[1:0]] = data;
      default: ;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] key_word(input int unsigned i);
    logic [PAIR_W-1:0] p;
    p = key_pairs[(i >> 1) & 3];
    return (i & 1) ? p[PAIR_W-1:WORD_W] : p[WORD_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] lerp(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b,
                                           input int unsigned ratio);
    int unsigned ia, ib;
    ia = a;
    ib = b;
    return CH_W'((ia * (255 - ratio) + ib * ratio) / 255);
  endfunction

  // advances the timeline and returns the color the block must produce
  function automatic color_t blend_color(input logic [STEP_W-1:0] step);
    int unsigned span, t, n, ph, prog, gap, ratio;
    logic [WORD_W-1:0] lw, rw, w, tmp;
    color_t c;
    span = (key_span == 0) ? 1 : key_span;
    t = timeline + step;
    n = (key_count > KEYS) ? KEYS : key_count;
    if (t >= span) begin
      t -= span;
      if (t >= span) t = span - 1;
    end
    timeline = SPAN_W'(t);
    ph = (255 * t) / span;
    c.phase = QUO_W'(ph);
    if (n == 0) begin
      c.red   = GREY;
      c.green = GREY;
      c.blue  = GREY;
    end else if (n == 1) begin
      w = key_word(0);
      c.red   = w[15:8];
      c.green = w[23:16];
      c.blue  = w[31:24];
    end else begin
      lw = key_word(0);
      rw = key_word(n - 1);
      if (ph <= lw[7:0] || ph >= rw[7:0]) begin
        tmp = lw;
        lw  = rw;
        rw  = tmp;
      end else begin
        for (int i = 1; i + 1 < n; i++) begin
          w = key_word(i);
          if (w[7:0] <= ph && w[7:0] > lw[7:0]) lw = w;
          if (w[7:0] >= ph && w[7:0] < rw[7:0]) rw = w;
        end
      end
      prog = (ph - 32'(lw[7:0])) & 32'hFF;
      gap  = (32'(rw[7:0]) - 32'(lw[7:0])) & 32'hFF;
      if (gap > 0) begin
        ratio = (255 * prog) / gap;
        if (ratio > 255) ratio = 255;
      end else begin
        ratio = 0;
      end
      c.red   = lerp(lw[15:8],  rw[15:8],  ratio);
      c.green = lerp(lw[23:16], rw[23:16], ratio);
      c.blue  = lerp(lw[31:24], rw[31:24], ratio);
    end
    return c;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= PRINT_CAP)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // driver: time steps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || step_taken) begin
      if (step_pending.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid     <= 1'b1;
        in_time_step <= step_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // driver: result acceptance
  always @(negedge clk) begin
    out_ready <= rst_n && !rx_hold && (steady || $urandom_range(99) >= IDLE_PCT);
  end

  initial begin : rx_backpressure
    wait (pressure_go);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin : monitor
    color_t got, want;
    bit moved;
    step_taken = 1'b0;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_write(cfg_index, cfg_data);
        n_writes++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        n_results++;
        got = {out_red, out_green, out_blue, out_phase};
        if (color_expected.size() == 0) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t ns: color with no transaction pending, got %h", $time, got);
        end else begin
          want = color_expected.pop_front();
          check_field("red",   want.red,   got.red);
          check_field("green", want.green, got.green);
          check_field("blue",  want.blue,  got.blue);
          check_field("phase", want.phase, got.phase);
        end
      end
      if (in_valid && in_ready) begin
        step_taken = 1'b1;
        moved = 1'b1;
        n_items++;
        color_expected.push_back(blend_color(in_time_step));
      end
    end
    stall_cnt = moved ? 0 : stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("cyclic_color_keyframe_blender regression: fail");
      $finish;
    end
  end

  function automatic void offer(input logic [STEP_W-1:0] step);
    step_pending.push_back(step);
    n_queued++;
  endfunction

  function automatic void put_key(input int i, input logic [7:0] t);
    plan_pairs[i / 2][(i % 2) * WORD_W +: WORD_W] = {8'($urandom), 8'($urandom), 8'($urandom), t};
  endfunction

  function automatic void make_sorted_keys();
    byte unsigned times [$];
    for (int i = 0; i < KEYS; i++) times.push_back(8'($urandom));
    times.sort();
    for (int i = 0; i < KEYS; i++) put_key(i, times[i]);
  endfunction

  // caller sits on a falling edge; returns on the falling edge after acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAIR_W-1:0] data);
    int base;
    base = n_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (n_writes == base);
  endtask

  task automatic write_keys();
    write_reg(REG_PAIR_0, plan_pairs[0]);
    write_reg(REG_PAIR_1, plan_pairs[1]);
    write_reg(REG_PAIR_2, plan_pairs[2]);
    write_reg(REG_PAIR_3, plan_pairs[3]);
  endtask

  task automatic drain();
    do @(negedge clk); while (n_items != n_queued || color_expected.size() != 0);
  endtask

  task automatic queue_steps(input int unsigned cap, input int num);
    for (int k = 0; k < num; k++) begin
      case ($urandom_range(2))
        0:       offer(STEP_W'($urandom));
        1:       offer(STEP_W'($urandom_range(cap)));
        default: offer(STEP_W'($urandom_range(cap / 8)));
      endcase
    end
  endtask

  task automatic random_setup(input int p, output int unsigned cap);
    logic [SPAN_W-1:0] s;
    logic [CNT_W-1:0]  n;
    logic [PAIR_W-1:0] fill;
    if (p == 0) s = SPAN_W'(1);
    else if (p == 1) s = '1;
    else begin
      case ($urandom_range(3))
        0:       s = SPAN_W'($urandom_range(1, 300));
        1:       s = SPAN_W'($urandom_range(65535));
        2:       s = SPAN_W'($urandom_range(250, 2000));
        default: s = SPAN_W'($urandom_range(1, 40));
      endcase
    end
    if (p == 2) n = CNT_W'(KEYS);
    else if (p == 3) n = CNT_W'(2);
    else if ($urandom_range(4) == 0) n = CNT_W'($urandom_range(15));
    else n = CNT_W'($urandom_range(2, KEYS));
    if ($urandom_range(4) == 0) begin
      for (int i = 0; i < NUM_PAIRS; i++) plan_pairs[i] = {$urandom, $urandom};
    end else begin
      make_sorted_keys();
    end
    cap = (s == 0) ? 1 : s;
    fill = {$urandom, $urandom};
    @(negedge clk);
    write_reg(REG_TIME_SPAN, {fill[PAIR_W-1:SPAN_W], s});
    write_reg(REG_POINT_COUNT, {fill[PAIR_W-1:CNT_W], n});
    write_keys();
    cfg_valid <= 1'b0;
    n_setups++;
  endtask

  initial begin : main_seq
    int unsigned cap;
    reset_keys();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // power-on settings, wrap and saturation of the timeline
    n_setups++;
    offer(16'd0);
    offer(16'd1);
    offer(16'd998);
    offer(16'd1);
    offer(16'hFFFF);
    offer(16'h5555);
    offer(16'hAAAA);
    offer(16'd500);
    drain();

    // zero span, no points, spare register slots
    @(negedge clk);
    write_reg(REG_TIME_SPAN, '0);
    write_reg(REG_POINT_COUNT, '0);
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    n_setups++;
    offer(16'd0);
    offer(16'hFFFF);
    offer(16'd7);
    drain();

    // single point; then span lowered while time is large
    @(negedge clk);
    write_reg(REG_TIME_SPAN, 64'd65535);
    write_reg(REG_POINT_COUNT, 64'd1);
    write_reg(REG_PAIR_0, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    n_setups++;
    offer(16'd60000);
    offer(16'd0);
    drain();
    @(negedge clk);
    write_reg(REG_TIME_SPAN, 64'd10);
    cfg_valid <= 1'b0;
    offer(16'd0);
    offer(16'd3);
    drain();

    // oversized count with repeated key times
    put_key(0, 8'd0);
    put_key(1, 8'd0);
    put_key(2, 8'd40);
    put_key(3, 8'd40);
    put_key(4, 8'd100);
    put_key(5, 8'd200);
    put_key(6, 8'd200);
    put_key(7, 8'd255);
    @(negedge clk);
    write_reg(REG_TIME_SPAN, 64'd256);
    write_reg(REG_POINT_COUNT, 64'd15);
    write_keys();
    cfg_valid <= 1'b0;
    n_setups++;
    offer(16'd0);
    offer(16'd20);
    offer(16'd20);
    offer(16'd60);
    offer(16'd100);
    drain();

    // keys out of order
    put_key(0, 8'd200);
    put_key(1, 8'd10);
    put_key(2, 8'd150);
    put_key(3, 8'd50);
    put_key(4, 8'd90);
    @(negedge clk);
    write_reg(REG_TIME_SPAN, 64'd100);
    write_reg(REG_POINT_COUNT, 64'd5);
    write_keys();
    cfg_valid <= 1'b0;
    n_setups++;
    offer(16'd10);
    offer(16'd25);
    offer(16'd25);
    offer(16'd30);
    offer(16'd40);
    drain();

    for (int p = 0; p < RAND_SETUPS; p++) begin
      random_setup(p, cap);
      steady <= (p == 4);
      if (p == 6) pressure_go <= 1'b1;
      queue_steps(cap, SETUP_STEPS);
      drain();
    end
    steady <= 1'b0;

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (color_expected.size() != 0) begin
      errors += color_expected.size();
      $display("%0t ns: %0d colors never delivered", $time, color_expected.size());
    end
    $display("%0d time steps over %0d key setups, %0d register writes, %0d colors checked",
             n_items, n_setups, n_writes, n_results);
    $display("included zero span, no/one key, oversized count, unsorted keys, long backpressure");
    if (errors == 0) begin
      $display("cyclic_color_keyframe_blender regression: pass");
    end else begin
      $display("cyclic_color_keyframe_blender regression: fail");
    end
    $finish;
  end

endmodule
